>>> rtl/core/dar_pkg.sv
// dar_pkg: shared types, codes and reply byte layout for the dhcp auto responder
// no dependencies; imported by every module in rtl/core
`default_nettype none

package dar_pkg;

  // fixed sizes of the request and reply layouts
  localparam int REPLY_LEN           = 274;
  localparam int OUT_BYTES_PER_WORD  = 8;
  localparam int JOB_QUEUE_DEPTH     = 2;

  localparam logic [15:0] OPT_START_IDX  = 16'd240;
  localparam logic [15:0] COOKIE_IDX     = 16'd236;
  localparam logic [15:0] MIN_LAST_IDX   = 16'd239;

  localparam logic [7:0] COOKIE_B0 = 8'h63;
  localparam logic [7:0] COOKIE_B1 = 8'h82;
  localparam logic [7:0] COOKIE_B2 = 8'h53;
  localparam logic [7:0] COOKIE_B3 = 8'h63;

  localparam logic [7:0] OPT_PAD      = 8'd0;
  localparam logic [7:0] OPT_END      = 8'd255;
  localparam logic [7:0] OPT_MSG_TYPE = 8'd53;

  localparam logic [7:0] DHCP_DISCOVER = 8'd1;
  localparam logic [7:0] DHCP_OFFER    = 8'd2;
  localparam logic [7:0] DHCP_REQUEST  = 8'd3;
  localparam logic [7:0] DHCP_ACK      = 8'd5;
  localparam logic [7:0] BOOT_REPLY    = 8'd2;

  typedef enum logic [2:0] {
    OUT_OFFER      = 3'd0,
    OUT_ACK        = 3'd1,
    OUT_SHORT      = 3'd2,
    OUT_BAD_COOKIE = 3'd3,
    OUT_NO_ANSWER  = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    PH_TYPE  = 2'd0,
    PH_LEN   = 2'd1,
    PH_VALUE = 2'd2,
    PH_SKIP  = 2'd3
  } opt_phase_t;

  typedef enum logic [2:0] {
    CFG_CLIENT_IP   = 3'd0,
    CFG_SERVER_IP   = 3'd1,
    CFG_SUBNET_MASK = 3'd2,
    CFG_DNS_SERVER  = 3'd3,
    CFG_LEASE       = 3'd4
  } cfg_index_t;

  localparam logic [31:0] RST_CLIENT_IP   = 32'd167772687;
  localparam logic [31:0] RST_SERVER_IP   = 32'd167772674;
  localparam logic [31:0] RST_SUBNET_MASK = 32'd4294967040;
  localparam logic [31:0] RST_DNS_SERVER  = 32'd134744072;
  localparam logic [31:0] RST_LEASE       = 32'd86400;

  typedef struct packed {
    logic [31:0] client_ip;
    logic [31:0] server_ip;
    logic [31:0] subnet_mask;
    logic [31:0] dns_server;
    logic [31:0] lease_seconds;
  } dar_cfg_t;

  // one classified request, handed from the parser to the emitter
  typedef struct packed {
    outcome_t     outcome;
    logic [7:0]   hw_type;
    logic [7:0]   hw_len;
    logic [31:0]  transaction_id;
    logic [15:0]  flag_bits;
    logic [31:0]  relay_address;
    logic [127:0] client_hw_address;
  } dar_job_t;

  // big endian byte k of a 32-bit value
  function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] k);
    logic [7:0] r;
    case (k)
      2'd0:    r = v[31:24];
      2'd1:    r = v[23:16];
      2'd2:    r = v[15:8];
      default: r = v[7:0];
    endcase
    return r;
  endfunction

  // byte at address a of the reply built from a job and the config
  function automatic logic [7:0] reply_byte(input logic [8:0] a, input dar_job_t j,
                                            input dar_cfg_t c);
    logic [7:0] r;
    logic [3:0] hi;
    logic [7:0] kind;
    hi   = 4'(a - 9'd28);
    kind = (j.outcome == OUT_OFFER) ? DHCP_OFFER : DHCP_ACK;
    case (a) inside
      9'd0:             r = BOOT_REPLY;
      9'd1:             r = j.hw_type;
      9'd2:             r = j.hw_len;
      [9'd4:9'd7]:      r = be_byte(j.transaction_id, 2'(a - 9'd4));
      9'd10:            r = j.flag_bits[15:8];
      9'd11:            r = j.flag_bits[7:0];
      [9'd16:9'd19]:    r = be_byte(c.client_ip, 2'(a - 9'd16));
      [9'd20:9'd23]:    r = be_byte(c.server_ip, 2'(a - 9'd20));
      [9'd24:9'd27]:    r = be_byte(j.relay_address, 2'(a - 9'd24));
      [9'd28:9'd43]:    r = j.client_hw_address[(7'd120 - {hi, 3'b000}) +: 8];
      9'd236:           r = COOKIE_B0;
      9'd237:           r = COOKIE_B1;
      9'd238:           r = COOKIE_B2;
      9'd239:           r = COOKIE_B3;
      9'd240:           r = OPT_MSG_TYPE;
      9'd241:           r = 8'd1;
      9'd242:           r = kind;
      9'd243:           r = 8'd54;
      9'd244:           r = 8'd4;
      [9'd245:9'd248]:  r = be_byte(c.server_ip, 2'(a - 9'd245));
      9'd249:           r = 8'd51;
      9'd250:           r = 8'd4;
      [9'd251:9'd254]:  r = be_byte(c.lease_seconds, 2'(a - 9'd251));
      9'd255:           r = 8'd1;
      9'd256:           r = 8'd4;
      [9'd257:9'd260]:  r = be_byte(c.subnet_mask, 2'(a - 9'd257));
      9'd261:           r = 8'd3;
      9'd262:           r = 8'd4;
      [9'd263:9'd266]:  r = be_byte(c.server_ip, 2'(a - 9'd263));
      9'd267:           r = 8'd6;
      9'd268:           r = 8'd4;
      [9'd269:9'd272]:  r = be_byte(c.dns_server, 2'(a - 9'd269));
      9'd273:           r = OPT_END;
      default:          r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/dar_front.sv
// dar_front: byte-serial request parser, captures header fields and scans options
// depends on dar_pkg; pushes one dar_job_t per request into the job queue
`default_nettype none

module dar_front import dar_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] req_byte,
  input  wire logic       final_byte,
  input  wire logic       q_full,
  output logic            push,
  output dar_job_t        job
);

  logic [15:0]  byte_index, byte_index_next;
  opt_phase_t   option_phase, option_phase_next;
  logic [7:0]   option_skip, option_skip_next;
  logic [7:0]   pending_type, pending_type_next;
  logic [7:0]   message_type, message_type_next;
  logic         type_found, type_found_next;
  logic         scan_stopped, scan_stopped_next;
  logic         cookie_ok, cookie_ok_next;
  logic [7:0]   hw_type, hw_type_next;
  logic [7:0]   hw_len, hw_len_next;
  logic [31:0]  transaction_id, transaction_id_next;
  logic [15:0]  flag_bits, flag_bits_next;
  logic [31:0]  relay_address, relay_address_next;
  logic [127:0] client_hw_address, client_hw_address_next;
  logic [7:0]   cookie_exp;
  logic         accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && final_byte;

  always_comb begin
    case (2'(byte_index - COOKIE_IDX))
      2'd0:    cookie_exp = COOKIE_B0;
      2'd1:    cookie_exp = COOKIE_B1;
      2'd2:    cookie_exp = COOKIE_B2;
      default: cookie_exp = COOKIE_B3;
    endcase
  end

  // field capture and option scan for the current byte
  always_comb begin
    byte_index_next        = (byte_index == 16'hFFFF) ? byte_index : byte_index + 16'd1;
    option_phase_next      = option_phase;
    option_skip_next       = option_skip;
    pending_type_next      = pending_type;
    message_type_next      = message_type;
    type_found_next        = type_found;
    scan_stopped_next      = scan_stopped;
    cookie_ok_next         = cookie_ok;
    hw_type_next           = hw_type;
    hw_len_next            = hw_len;
    transaction_id_next    = transaction_id;
    flag_bits_next         = flag_bits;
    relay_address_next     = relay_address;
    client_hw_address_next = client_hw_address;
    if (byte_index == 16'd1) begin
      hw_type_next = req_byte;
    end else if (byte_index == 16'd2) begin
      hw_len_next = req_byte;
    end else if (byte_index >= 16'd4 && byte_index <= 16'd7) begin
      transaction_id_next = {transaction_id[23:0], req_byte};
    end else if (byte_index == 16'd10 || byte_index == 16'd11) begin
      flag_bits_next = {flag_bits[7:0], req_byte};
    end else if (byte_index >= 16'd24 && byte_index <= 16'd27) begin
      relay_address_next = {relay_address[23:0], req_byte};
    end else if (byte_index >= 16'd28 && byte_index <= 16'd43) begin
      client_hw_address_next = {client_hw_address[119:0], req_byte};
    end else if (byte_index >= COOKIE_IDX && byte_index <= MIN_LAST_IDX) begin
      if (req_byte != cookie_exp) begin
        cookie_ok_next = 1'b0;
      end
    end else if (byte_index >= OPT_START_IDX && !scan_stopped && !type_found) begin
      unique case (option_phase)
        PH_TYPE: begin
          if (req_byte == OPT_END) begin
            scan_stopped_next = 1'b1;
          end else if (req_byte != OPT_PAD) begin
            pending_type_next = req_byte;
            option_phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          if (pending_type == OPT_MSG_TYPE && req_byte != 8'd0) begin
            option_phase_next = PH_VALUE;
          end else if (req_byte == 8'd0) begin
            option_phase_next = PH_TYPE;
          end else begin
            option_skip_next  = req_byte;
            option_phase_next = PH_SKIP;
          end
        end
        PH_VALUE: begin
          message_type_next = req_byte;
          type_found_next   = 1'b1;
        end
        PH_SKIP: begin
          if (option_skip <= 8'd1) begin
            option_skip_next  = 8'd0;
            option_phase_next = PH_TYPE;
          end else begin
            option_skip_next = option_skip - 8'd1;
          end
        end
        default: option_phase_next = PH_TYPE;
      endcase
    end
  end

  // classification on the last byte, refusals in priority order
  always_comb begin
    job.hw_type           = hw_type_next;
    job.hw_len            = hw_len_next;
    job.transaction_id    = transaction_id_next;
    job.flag_bits         = flag_bits_next;
    job.relay_address     = relay_address_next;
    job.client_hw_address = client_hw_address_next;
    if (byte_index < MIN_LAST_IDX) begin
      job.outcome = OUT_SHORT;
    end else if (!cookie_ok_next) begin
      job.outcome = OUT_BAD_COOKIE;
    end else if (type_found_next && message_type_next == DHCP_DISCOVER) begin
      job.outcome = OUT_OFFER;
    end else if (type_found_next && message_type_next == DHCP_REQUEST) begin
      job.outcome = OUT_ACK;
    end else begin
      job.outcome = OUT_NO_ANSWER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      byte_index   <= '0;
      option_phase <= PH_TYPE;
      option_skip  <= '0;
      pending_type <= '0;
      message_type <= '0;
      type_found   <= 1'b0;
      scan_stopped <= 1'b0;
      cookie_ok    <= 1'b1;
    end else if (accept) begin
      byte_index   <= byte_index_next;
      option_phase <= option_phase_next;
      option_skip  <= option_skip_next;
      pending_type <= pending_type_next;
      message_type <= message_type_next;
      type_found   <= type_found_next;
      scan_stopped <= scan_stopped_next;
      cookie_ok    <= cookie_ok_next;
    end
  end

  // captured fields have no reset; each request rewrites those whose byte positions it reaches
  always_ff @(posedge clk) begin
    if (accept) begin
      hw_type           <= hw_type_next;
      hw_len            <= hw_len_next;
      transaction_id    <= transaction_id_next;
      flag_bits         <= flag_bits_next;
      relay_address     <= relay_address_next;
      client_hw_address <= client_hw_address_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/dar_queue.sv
// dar_queue: short job queue between the parser and the reply emitter
// depends on dar_pkg for dar_job_t and JOB_QUEUE_DEPTH
`default_nettype none

module dar_queue import dar_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire dar_job_t push_job,
  output logic          full,
  output logic          not_empty,
  input  wire logic     pop,
  output dar_job_t      head
);

  localparam int PW = (JOB_QUEUE_DEPTH > 1) ? $clog2(JOB_QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(JOB_QUEUE_DEPTH + 1);

  dar_job_t        entries [JOB_QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign full      = (count == CW'(JOB_QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(JOB_QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(JOB_QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("job pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty) else $error("job popped from an empty queue");

endmodule

`default_nettype wire

>>> rtl/core/dar_back.sv
// dar_back: reply emitter, turns queued jobs into reply words in an output register
// depends on dar_pkg for the reply layout function and job/config types
`default_nettype none

module dar_back import dar_pkg::*; #(
  parameter int OUT_BYTES_PER_WORD = dar_pkg::OUT_BYTES_PER_WORD
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dar_cfg_t    cfg,
  input  wire logic        q_not_empty,
  input  wire dar_job_t    head,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      reply_word,
  output logic [3:0]       byte_count,
  output logic             last_word,
  output logic [2:0]       outcome
);

  localparam logic [8:0] W9  = 9'(OUT_BYTES_PER_WORD);
  localparam logic [3:0] W4  = 4'(OUT_BYTES_PER_WORD);
  localparam logic [8:0] LEN = 9'(REPLY_LEN);

  logic [8:0]  pos, pos_next;
  logic [8:0]  remain;
  logic        load, refuse, fire;
  logic [63:0] word_next;
  logic [3:0]  count_next;
  logic        last_next;
  logic [8:0]  lane_addr [8];

  assign load   = !out_valid || !out_stall;
  assign fire   = load && q_not_empty;
  assign refuse = (head.outcome != OUT_OFFER) && (head.outcome != OUT_ACK);
  assign remain = LEN - pos;

  always_comb begin
    word_next = '0;
    for (int k = 0; k < 8; k++) begin
      lane_addr[k] = pos + 9'(k);
      if (!refuse && k < OUT_BYTES_PER_WORD && lane_addr[k] < LEN) begin
        word_next[63 - 8*k -: 8] = reply_byte(lane_addr[k], head, cfg);
      end
    end
    if (refuse) begin
      count_next = '0;
      last_next  = 1'b1;
      pos_next   = '0;
    end else begin
      count_next = (remain >= W9) ? W4 : remain[3:0];
      last_next  = (remain <= W9);
      pos_next   = last_next ? '0 : pos + W9;
    end
    pop = fire && last_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else if (load) begin
      out_valid <= q_not_empty;
      if (q_not_empty) begin
        pos <= pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      reply_word <= word_next;
      byte_count <= count_next;
      last_word  <= last_next;
      outcome    <= head.outcome;
    end
  end

  a_refusal_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (outcome == OUT_SHORT || outcome == OUT_BAD_COOKIE ||
                  outcome == OUT_NO_ANSWER) |-> byte_count == 4'd0 && last_word)
    else $error("refusal carries reply bytes");
  a_full_words: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_word |-> byte_count == W4)
    else $error("partial word before the end of a reply");
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos < LEN) else $error("reply position past the end");

endmodule

`default_nettype wire

>>> rtl/core/dhcp_auto_responder.sv
// dhcp_auto_responder: top level, config registers, parser, job queue and emitter
// depends on dar_pkg, dar_front, dar_queue and dar_back
// first reply word: job queued on last byte, then loaded into the output register (idle emitter)
// throughput: 1 request byte per cycle, stalled only while the job queue is full;
//   1 reply word per cycle while out_stall is low, ceil(274 / bytes per word) words
//   per answered request (35 at 8 bytes), 1 word per refused request
// reset: synchronous, clears parser, queue and output valid, config back to defaults
`default_nettype none

module dhcp_auto_responder import dar_pkg::*; #(
  parameter int OUT_BYTES_PER_WORD = dar_pkg::OUT_BYTES_PER_WORD
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request byte stream
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  req_byte,
  input  wire logic        final_byte,
  // reply word stream
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      reply_word,
  output logic [3:0]       byte_count,
  output logic             last_word,
  output logic [2:0]       outcome,
  // config write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // config registers, always writable; indexes past the list are dropped
  dar_cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.client_ip     <= RST_CLIENT_IP;
      cfg.server_ip     <= RST_SERVER_IP;
      cfg.subnet_mask   <= RST_SUBNET_MASK;
      cfg.dns_server    <= RST_DNS_SERVER;
      cfg.lease_seconds <= RST_LEASE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CLIENT_IP:   cfg.client_ip     <= cfg_data;
        CFG_SERVER_IP:   cfg.server_ip     <= cfg_data;
        CFG_SUBNET_MASK: cfg.subnet_mask   <= cfg_data;
        CFG_DNS_SERVER:  cfg.dns_server    <= cfg_data;
        CFG_LEASE:       cfg.lease_seconds <= cfg_data;
        default: ;
      endcase
    end
  end

  // parser -> queue: one classified job per request, pushed on the last byte
  logic     push, q_full, q_not_empty, pop;
  dar_job_t push_job, head;

  dar_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_byte   (req_byte),
    .final_byte (final_byte),
    .q_full     (q_full),
    .push       (push),
    .job        (push_job)
  );

  // decouples parsing of the next request from emission of the current reply
  dar_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (pop),
    .head      (head)
  );

  // emitter builds reply bytes from the head job and live config
  dar_back #(
    .OUT_BYTES_PER_WORD (OUT_BYTES_PER_WORD)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .reply_word  (reply_word),
    .byte_count  (byte_count),
    .last_word   (last_word),
    .outcome     (outcome)
  );

endmodule

`default_nettype wire
